// ===== rtl/assert_macros.svh =====
// Assertion macros used by the controller RTL of the farthest-pair bounding sphere unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FPBS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define FPBS_ASSERT_NEVER(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);

`else

`define FPBS_ASSERT(label, clk, rstn, prop, msg)

`define FPBS_ASSERT_NEVER(label, clk, rstn, prop, msg)

`endif

`endif

// ===== rtl/fpbs_pkg.sv =====
// Package: widths, codes, state type and control structs of the bounding sphere unit.
package fpbs_pkg;

    localparam int COORD_W        = 24;
    localparam int PT_W           = 3 * COORD_W;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int SQ_W           = 2 * DIFF_W - 1;
    localparam int D2_W           = SQ_W + 1;
    localparam int ROOT_W         = D2_W / 2;
    localparam int REM_W          = ROOT_W + 2;
    localparam int RADIUS_W       = ROOT_W - 1;
    localparam int OUT_IDX_W      = 6;
    localparam int ERR_W          = 2;
    localparam int SQRT_STEPS     = ROOT_W;
    localparam int STEP_W         = $clog2(SQRT_STEPS);
    localparam int MAX_POINTS_DEF = 64;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 2'd0,
        ERR_FEW     = 2'd1,
        ERR_DROPPED = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_best;
        logic pair_valid;
        logic first_pair;
        logic sqrt_init;
        logic sqrt_step;
        logic load_result;
        logic short_set;
        logic dropped;
    } fpbs_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic slot_free;
    } fpbs_stat_t;

endpackage

// ===== rtl/fpbs_point_if.sv =====
// Interface: point input channel (valid/ready with one 3D point per beat).
interface fpbs_point_if;
    import fpbs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;

    modport source (output valid, output x, output y, output z, output last, input ready);
    modport sink   (input valid, input x, input y, input z, input last, output ready);
endinterface

// ===== rtl/fpbs_sphere_if.sv =====
// Interface: sphere result channel (valid/ready with one result per beat).
interface fpbs_sphere_if;
    import fpbs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   center_x;
    logic signed [COORD_W-1:0]   center_y;
    logic signed [COORD_W-1:0]   center_z;
    logic        [RADIUS_W-1:0]  sphere_radius;
    logic        [OUT_IDX_W-1:0] first_index;
    logic        [OUT_IDX_W-1:0] second_index;
    logic        [ERR_W-1:0]     error;

    modport source (output valid, output center_x, output center_y, output center_z,
                    output sphere_radius, output first_index, output second_index,
                    output error, input ready);
    modport sink   (input valid, input center_x, input center_y, input center_z,
                    input sphere_radius, input first_index, input second_index,
                    input error, output ready);
endinterface

// ===== rtl/fpbs_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module fpbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

// ===== rtl/fpbs_datapath.sv =====
// Datapath: point store, squared-distance pipeline, best pair, square root, result register.
module fpbs_datapath #(
    parameter int MAX_POINTS = fpbs_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpbs_pkg::fpbs_cmd_t                 cmd,
    output fpbs_pkg::fpbs_stat_t                stat,
    input  logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]       rd_a,
    input  logic [$clog2(MAX_POINTS)-1:0]       rd_b,
    input  logic signed [fpbs_pkg::COORD_W-1:0] pt_x,
    input  logic signed [fpbs_pkg::COORD_W-1:0] pt_y,
    input  logic signed [fpbs_pkg::COORD_W-1:0] pt_z,
    input  logic                                res_ready,
    output logic                                res_valid,
    output logic signed [fpbs_pkg::COORD_W-1:0] center_x,
    output logic signed [fpbs_pkg::COORD_W-1:0] center_y,
    output logic signed [fpbs_pkg::COORD_W-1:0] center_z,
    output logic [fpbs_pkg::RADIUS_W-1:0]       sphere_radius,
    output logic [fpbs_pkg::OUT_IDX_W-1:0]      first_index,
    output logic [fpbs_pkg::OUT_IDX_W-1:0]      second_index,
    output logic [fpbs_pkg::ERR_W-1:0]          error
);
    import fpbs_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    logic [PT_W-1:0]  rd_data_a, rd_data_b;
    logic [IDX_W-1:0] addr_a, addr_b;

    // pair pipeline: read -> abs diff -> square -> sum -> compare
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             f1_reg, f2_reg, f3_reg, f4_reg;
    logic [IDX_W-1:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic [IDX_W-1:0] b1_reg, b2_reg, b3_reg, b4_reg;

    logic signed [COORD_W-1:0] ca [3];
    logic signed [COORD_W-1:0] cb [3];
    logic signed [DIFF_W-1:0]  diff [3];
    logic signed [DIFF_W-1:0]  msum [3];
    logic [DIFF_W-1:0]         ad_next [3];
    logic [DIFF_W-1:0]         ad_reg [3];
    logic [2*DIFF_W-1:0]       prod [3];
    logic [SQ_W-1:0]           sq_reg [3];
    logic [D2_W-1:0]           sum_next, sum_reg;

    logic [D2_W-1:0]  best_d2_reg;
    logic [IDX_W-1:0] best_a_reg, best_b_reg;

    logic [D2_W-1:0]   sq_val_reg, sq_val_next;
    logic [REM_W-1:0]  sq_rem_reg, sq_rem_next, rem_sh, trial;
    logic [ROOT_W-1:0] sq_root_reg, sq_root_next;

    logic [IDX_W+OUT_IDX_W-1:0] ext_a, ext_b;

    logic                      res_valid_reg, res_valid_next;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic [RADIUS_W-1:0]       rad_reg, rad_next;
    logic [OUT_IDX_W-1:0]      fi_reg, si_reg, fi_next, si_next;
    logic [ERR_W-1:0]          err_reg, err_next;

    assign addr_a = cmd.rd_best ? best_a_reg : rd_a;
    assign addr_b = cmd.rd_best ? best_b_reg : rd_b;

    fpbs_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .we      (cmd.wr_en),
        .waddr   (wr_addr),
        .wdata   ({pt_x, pt_y, pt_z}),
        .re      (cmd.rd_en),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_data_a),
        .rdata_b (rd_data_b)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ca[k]      = rd_data_a[(2-k)*COORD_W +: COORD_W];
            cb[k]      = rd_data_b[(2-k)*COORD_W +: COORD_W];
            diff[k]    = DIFF_W'(ca[k]) - DIFF_W'(cb[k]);
            msum[k]    = DIFF_W'(ca[k]) + DIFF_W'(cb[k]);
            ad_next[k] = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
            prod[k]    = ad_reg[k] * ad_reg[k];
        end
        sum_next = D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.pair_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg <= cmd.first_pair;
        a1_reg <= rd_a;
        b1_reg <= rd_b;
        f2_reg <= f1_reg;
        a2_reg <= a1_reg;
        b2_reg <= b1_reg;
        f3_reg <= f2_reg;
        a3_reg <= a2_reg;
        b3_reg <= b2_reg;
        f4_reg <= f3_reg;
        a4_reg <= a3_reg;
        b4_reg <= b3_reg;
        for (int k = 0; k < 3; k++)
        begin
            ad_reg[k] <= ad_next[k];
            sq_reg[k] <= prod[k][SQ_W-1:0];
        end
        sum_reg <= sum_next;
        // first pair of a scan loads unconditionally; later ones only if strictly farther
        if (v4_reg && (f4_reg || (sum_reg > best_d2_reg)))
        begin
            best_d2_reg <= sum_reg;
            best_a_reg  <= a4_reg;
            best_b_reg  <= b4_reg;
        end
    end

    // restoring square root, two radicand bits per step
    always_comb
    begin
        rem_sh       = {sq_rem_reg[REM_W-3:0], sq_val_reg[D2_W-1 -: 2]};
        trial        = {sq_root_reg, 2'b01};
        sq_val_next  = sq_val_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        if (cmd.sqrt_init)
        begin
            sq_val_next  = best_d2_reg;
            sq_rem_next  = '0;
            sq_root_next = '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_val_next = {sq_val_reg[D2_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                sq_rem_next  = rem_sh - trial;
                sq_root_next = {sq_root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next  = rem_sh;
                sq_root_next = {sq_root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_val_reg  <= sq_val_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
    end

    assign ext_a = {{OUT_IDX_W{1'b0}}, best_a_reg};
    assign ext_b = {{OUT_IDX_W{1'b0}}, best_b_reg};

    always_comb
    begin
        res_valid_next = res_valid_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        cz_next  = cz_reg;
        rad_next = rad_reg;
        fi_next  = fi_reg;
        si_next  = si_reg;
        err_next = err_reg;
        priority if (cmd.load_result)
        begin
            res_valid_next = 1'b1;
            if (cmd.short_set)
            begin
                cx_next  = '0;
                cy_next  = '0;
                cz_next  = '0;
                rad_next = '0;
                fi_next  = '0;
                si_next  = '0;
                err_next = ERR_FEW;
            end
            else
            begin
                // floor((a+b)/2): drop the low bit of the signed sum
                cx_next  = msum[0][DIFF_W-1:1];
                cy_next  = msum[1][DIFF_W-1:1];
                cz_next  = msum[2][DIFF_W-1:1];
                rad_next = sq_root_reg[ROOT_W-1:1];
                fi_next  = ext_a[OUT_IDX_W-1:0];
                si_next  = ext_b[OUT_IDX_W-1:0];
                err_next = cmd.dropped ? ERR_DROPPED : ERR_OK;
            end
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        cz_reg  <= cz_next;
        rad_reg <= rad_next;
        fi_reg  <= fi_next;
        si_reg  <= si_next;
        err_reg <= err_next;
    end

    assign stat.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign stat.slot_free = !res_valid_reg || res_ready;

    assign res_valid     = res_valid_reg;
    assign center_x      = cx_reg;
    assign center_y      = cy_reg;
    assign center_z      = cz_reg;
    assign sphere_radius = rad_reg;
    assign first_index   = fi_reg;
    assign second_index  = si_reg;
    assign error         = err_reg;
endmodule

// ===== rtl/fpbs_ctrl.sv =====
// Controller: load counter, pair scan sequencer and result sequencing.
`include "assert_macros.svh"

module fpbs_ctrl #(
    parameter int MAX_POINTS = fpbs_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pt_valid,
    input  logic                          pt_last,
    output logic                          pt_ready,
    input  fpbs_pkg::fpbs_stat_t          stat,
    output fpbs_pkg::fpbs_cmd_t           cmd,
    output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0] rd_a,
    output logic [$clog2(MAX_POINTS)-1:0] rd_b
);
    import fpbs_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic accept, store_full, j_end, last_pair;

    assign accept     = pt_valid && (state_reg == ST_IDLE);
    assign store_full = (count_reg == CNT_W'(MAX_POINTS));
    assign j_end      = (CNT_W'(j_reg) == count_reg - CNT_W'(1));
    assign last_pair  = j_end && (CNT_W'(i_reg) == count_reg - CNT_W'(2));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && pt_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = (count_reg < CNT_W'(2)) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last_pair)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_START:
            begin
                i_next = '0;
                j_next = IDX_W'(1);
            end
            ST_SCAN:
            begin
                if (!j_end)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
                else if (!last_pair)
                begin
                    i_next = i_reg + IDX_W'(1);
                    j_next = i_reg + IDX_W'(2);
                end
            end
            ST_FETCH:
            begin
                step_next = '0;
            end
            ST_SQRT:
            begin
                step_next = step_reg + STEP_W'(1);
            end
            ST_DONE:
            begin
                if (stat.slot_free)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.wr_en       = accept && !store_full;
        cmd.pair_valid  = (state_reg == ST_SCAN);
        cmd.first_pair  = (state_reg == ST_SCAN) && (i_reg == '0) && (j_reg == IDX_W'(1));
        cmd.rd_best     = (state_reg == ST_FETCH);
        cmd.rd_en       = (state_reg == ST_SCAN) || (state_reg == ST_FETCH);
        cmd.sqrt_init   = (state_reg == ST_FETCH);
        cmd.sqrt_step   = (state_reg == ST_SQRT);
        cmd.load_result = (state_reg == ST_DONE) && stat.slot_free;
        cmd.short_set   = (count_reg < CNT_W'(2));
        cmd.dropped     = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            step_reg  <= step_next;
        end
    end

    assign pt_ready = (state_reg == ST_IDLE);
    assign wr_addr  = count_reg[IDX_W-1:0];
    assign rd_a     = i_reg;
    assign rd_b     = j_reg;

    `FPBS_ASSERT(a_ovf_full, clk, rst_n, ovf_reg |-> store_full, "overflow seen with store not full")
    `FPBS_ASSERT(a_scan_order, clk, rst_n, (state_reg == ST_SCAN) |-> (j_reg > i_reg), "pair out of order")
    `FPBS_ASSERT(a_result_slot, clk, rst_n, cmd.load_result |-> stat.slot_free, "result overwritten")
    `FPBS_ASSERT_NEVER(a_drain_exit, clk, rst_n, (state_reg == ST_DRAIN) && (state_next != ST_DRAIN) && stat.pipe_busy, "left drain with pairs in flight")
endmodule

// ===== rtl/farthest_pair_bounding_sphere_unit.sv =====
// Top level of the farthest-pair bounding sphere unit.
// Points stream in on the point channel, one per beat, and are stored in load
// order; the beat with last set starts the search. Points are taken only while
// the unit is idle. After the last point the controller walks every pair
// (i,j), i<j, one pair per cycle through a dual-read point memory and a
// four-stage squared-distance pipeline, then a 25-step restoring square root
// produces the radius. No new point is taken until the result is registered.
// The result sits in an output register, so the next set may load while it
// waits to be taken. Points past MAX_POINTS are dropped and flagged with
// error 2.
module farthest_pair_bounding_sphere_unit #(
    parameter int MAX_POINTS = fpbs_pkg::MAX_POINTS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    fpbs_point_if.sink    point,
    fpbs_sphere_if.source sphere
);
    import fpbs_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    fpbs_cmd_t        cmd;
    fpbs_stat_t       stat;
    logic [IDX_W-1:0] wr_addr, rd_a, rd_b;

    fpbs_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_valid (point.valid),
        .pt_last  (point.last),
        .pt_ready (point.ready),
        .stat     (stat),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_a     (rd_a),
        .rd_b     (rd_b)
    );

    fpbs_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .wr_addr       (wr_addr),
        .rd_a          (rd_a),
        .rd_b          (rd_b),
        .pt_x          (point.x),
        .pt_y          (point.y),
        .pt_z          (point.z),
        .res_ready     (sphere.ready),
        .res_valid     (sphere.valid),
        .center_x      (sphere.center_x),
        .center_y      (sphere.center_y),
        .center_z      (sphere.center_z),
        .sphere_radius (sphere.sphere_radius),
        .first_index   (sphere.first_index),
        .second_index  (sphere.second_index),
        .error         (sphere.error)
    );
endmodule

// ===== bench/tb_farthest_pair_bounding_sphere_unit.sv =====
// Testbench for the farthest-pair bounding sphere unit: directed and random point sets.
module tb_farthest_pair_bounding_sphere_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fpbs_pkg::*;

    localparam int CAPACITY = MAX_POINTS_DEF;
    localparam int RANDOM_POINTS = 230;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MIN = 24'h800000;
    localparam coord_t COORD_MAX = 24'h7FFFFF;
    localparam coord_t ONE_Q12 = 24'sd4096;

    typedef struct {
        coord_t                 cx;
        coord_t                 cy;
        coord_t                 cz;
        logic [RADIUS_W-1:0]    radius;
        logic [OUT_IDX_W-1:0]   first;
        logic [OUT_IDX_W-1:0]   second;
        err_t                   err;
    } sphere_result_t;

    logic clk = 1'b0;
    logic rst_n;

    fpbs_point_if  point_ch ();
    fpbs_sphere_if sphere_ch ();

    farthest_pair_bounding_sphere_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .sphere (sphere_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state: points of the set being loaded
    coord_t         held [CAPACITY][3];
    int             held_count = 0;
    logic           dropped_seen = 1'b0;
    sphere_result_t expected_spheres [$];
    sphere_result_t want_sphere;

    int mismatches = 0;
    int points_sent = 0;
    int gap_max = 10;
    int stall_max = 10;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    function automatic longint dist_sq(input int a, input int b);
        longint sum;
        longint d;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = longint'(held[a][k]) - longint'(held[b][k]);
            sum += d * d;
        end
        return sum;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_val;
        res = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > v)
            bit_val >>= 2;
        while (bit_val != 0)
        begin
            if (v >= res + bit_val)
            begin
                v -= res + bit_val;
                res = (res >> 1) + bit_val;
            end
            else
                res >>= 1;
            bit_val >>= 2;
        end
        return res;
    endfunction

    // floor of the mean, exact for any pair of 24-bit values
    function automatic coord_t half_sum(input coord_t a, input coord_t b);
        longint s;
        s = (longint'(a) + longint'(b)) >>> 1;
        return s[COORD_W-1:0];
    endfunction

    function automatic void predict_sphere(input coord_t px, input coord_t py,
                                           input coord_t pz, input logic lst);
        sphere_result_t r;
        longint d2;
        longint best_d2;
        int bi;
        int bj;
        if (held_count < CAPACITY)
        begin
            held[held_count][0] = px;
            held[held_count][1] = py;
            held[held_count][2] = pz;
            held_count++;
        end
        else
            dropped_seen = 1'b1;
        if (!lst)
            return;

        r.cx = '0;
        r.cy = '0;
        r.cz = '0;
        r.radius = '0;
        r.first = '0;
        r.second = '0;
        r.err = ERR_FEW;
        if (held_count >= 2)
        begin
            bi = 0;
            bj = 1;
            best_d2 = dist_sq(0, 1);
            for (int i = 0; i < held_count; i++)
                for (int j = i + 1; j < held_count; j++)
                begin
                    d2 = dist_sq(i, j);
                    // strict compare: earliest pair wins a tie
                    if (d2 > best_d2)
                    begin
                        best_d2 = d2;
                        bi = i;
                        bj = j;
                    end
                end
            r.cx = half_sum(held[bi][0], held[bj][0]);
            r.cy = half_sum(held[bi][1], held[bj][1]);
            r.cz = half_sum(held[bi][2], held[bj][2]);
            r.radius = RADIUS_W'(int_root(best_d2) >> 1);
            r.first = OUT_IDX_W'(bi);
            r.second = OUT_IDX_W'(bj);
            r.err = dropped_seen ? ERR_DROPPED : ERR_OK;
        end
        held_count = 0;
        dropped_seen = 1'b0;
        expected_spheres.push_back(r);
    endfunction

    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                              input logic lst);
        int gap;
        gap = $urandom_range(gap_max);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.x <= px;
        point_ch.y <= py;
        point_ch.z <= pz;
        point_ch.last <= lst;
        do @(posedge clk); while (!point_ch.ready);
        predict_sphere(px, py, pz, lst);
        points_sent++;
    endtask

    // style: 0 full range, 1 extremes, 2 small cluster, 3 coarse grid (ties)
    function automatic coord_t pick_coord(input int style);
        case (style)
            0: return coord_t'($urandom);
            1:
            begin
                case ($urandom_range(3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            2: return coord_t'(int'($urandom_range(128)) - 64);
            default: return coord_t'((int'($urandom_range(4)) - 2) * 4096);
        endcase
    endfunction

    // style below zero mixes styles per coordinate
    task automatic send_set(input int n, input int style);
        coord_t c [3];
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 3; k++)
                c[k] = pick_coord(style < 0 ? int'($urandom_range(3)) : style);
            send_point(c[0], c[1], c[2], i == n - 1);
        end
    endtask

    task automatic test_single_point();
        send_point('0, '0, '0, 1'b1);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    endtask

    task automatic test_extreme_pairs();
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
        send_point(24'h555555, 24'hAAAAAA, 24'h555555, 1'b0);
        send_point(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1);
    endtask

    task automatic test_equal_distances();
        // identical points: every distance is zero, first pair stays
        send_point(ONE_Q12, -ONE_Q12, ONE_Q12, 1'b0);
        send_point(ONE_Q12, -ONE_Q12, ONE_Q12, 1'b0);
        send_point(ONE_Q12, -ONE_Q12, ONE_Q12, 1'b1);
        // unit square: both diagonals tie, (0,2) comes first
        send_point('0, '0, '0, 1'b0);
        send_point(ONE_Q12, '0, '0, 1'b0);
        send_point(ONE_Q12, ONE_Q12, '0, 1'b0);
        send_point('0, ONE_Q12, '0, 1'b1);
    endtask

    task automatic test_late_pair_wins();
        send_point('0, '0, '0, 1'b0);
        send_point(ONE_Q12, '0, '0, 1'b0);
        send_point(coord_t'(-4 * ONE_Q12), '0, '0, 1'b0);
        send_point(coord_t'(4 * ONE_Q12), ONE_Q12, -ONE_Q12, 1'b1);
    endtask

    task automatic test_capacity();
        // exactly full, then overfull with the last three beats dropped
        send_set(CAPACITY, -1);
        send_set(CAPACITY + 3, 0);
    endtask

    task automatic test_back_to_back();
        gap_max = 0;
        stall_max = 0;
        for (int i = 0; i < 6; i++)
            send_set($urandom_range(1, 6), -1);
        gap_max = 10;
        stall_max = 10;
    endtask

    task automatic test_random_sets();
        int start;
        int pick;
        int n;
        start = points_sent;
        while (points_sent - start < RANDOM_POINTS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                n = $urandom_range(2, 8);
            else if (pick < 80)
                n = 1;
            else if (pick < 95)
                n = $urandom_range(9, 20);
            else
                n = $urandom_range(21, 40);
            gap_max = ($urandom_range(7) == 0) ? 0 : 10;
            stall_max = ($urandom_range(7) == 0) ? 0 : 10;
            send_set(n, int'($urandom_range(4)) - 1);
        end
        gap_max = 10;
        stall_max = 10;
    endtask

    // result side stalls
    initial
    begin
        int stall;
        sphere_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(stall_max);
            if (stall > 0)
            begin
                sphere_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sphere_ch.ready <= 1'b1;
            do @(posedge clk); while (!(sphere_ch.valid && sphere_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sphere_ch.valid && sphere_ch.ready)
        begin
            if (expected_spheres.size() == 0)
                report_mismatch("sphere beat with nothing expected");
            else
            begin
                want_sphere = expected_spheres.pop_front();
                check_field("center_x", 32'(sphere_ch.center_x), 32'(want_sphere.cx));
                check_field("center_y", 32'(sphere_ch.center_y), 32'(want_sphere.cy));
                check_field("center_z", 32'(sphere_ch.center_z), 32'(want_sphere.cz));
                check_field("sphere_radius", 32'(sphere_ch.sphere_radius),
                            32'(want_sphere.radius));
                check_field("first_index", 32'(sphere_ch.first_index),
                            32'(want_sphere.first));
                check_field("second_index", 32'(sphere_ch.second_index),
                            32'(want_sphere.second));
                check_field("error", 32'(sphere_ch.error), 32'(want_sphere.err));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        point_ch.valid = 1'b0;
        point_ch.x = '0;
        point_ch.y = '0;
        point_ch.z = '0;
        point_ch.last = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_point();
        test_extreme_pairs();
        test_equal_distances();
        test_late_pair_wins();
        test_capacity();
        test_back_to_back();
        test_random_sets();

        point_ch.valid <= 1'b0;
        while (expected_spheres.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("tb_farthest_pair_bounding_sphere_unit: clean");
        else
            $display("tb_farthest_pair_bounding_sphere_unit: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_farthest_pair_bounding_sphere_unit: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpbs_pkg.sv
rtl/fpbs_point_if.sv
rtl/fpbs_sphere_if.sv
rtl/fpbs_ram.sv
rtl/fpbs_datapath.sv
rtl/fpbs_ctrl.sv
rtl/farthest_pair_bounding_sphere_unit.sv
bench/tb_farthest_pair_bounding_sphere_unit.sv
